>>> rtl/telnet_iac_stream_parser_top_assert.svh
// Assertion macros for the Telnet IAC stream parser.
// The assertions sample on the rising edge of i_clk and are not checked while i_rst_n is low.
`ifndef TELNET_IAC_STREAM_PARSER_TOP_ASSERT_SVH
`define TELNET_IAC_STREAM_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TISP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define TISP_ASSERT_NEVER(lbl, expr, msg) \
    `TISP_ASSERT(lbl, !(expr), msg)
`else
`define TISP_ASSERT(lbl, prop, msg)
`define TISP_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

>>> rtl/tisp_pkg.sv
`default_nettype none
package tisp_pkg;

    localparam int SUB_COUNT_BITS = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_WILL = 8'd251;

    typedef enum logic [2:0] {
        KIND_DATA = 3'd0,
        KIND_CTRL = 3'd1,
        KIND_NEG  = 3'd2,
        KIND_SUBB = 3'd3,
        KIND_SUBE = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        OP_DATA      = 3'd0,
        OP_CTRL      = 3'd1,
        OP_NEG       = 3'd2,
        OP_SUB_START = 3'd3,
        OP_SUB_BYTE  = 3'd4,
        OP_SUB_END   = 3'd5
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] a;
        logic [7:0] b;
    } t_token;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage
`default_nettype wire

>>> rtl/tisp_front.sv
`default_nettype none
module tisp_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  wire  [7:0]            i_byte,
    input  wire                   i_full,
    output logic                  o_ready,
    output logic                  o_push,
    output tisp_pkg::t_token      o_token
);

    typedef enum logic [3:0] {
        ST_DATA = 4'b0001,
        ST_CMD  = 4'b0010,
        ST_OPT  = 4'b0100,
        ST_SUB  = 4'b1000
    } t_state;

    t_state     r_state, n_state;
    logic       r_pending, n_pending;
    logic [7:0] r_held_cmd, n_held_cmd;
    logic       accept;
    logic       gen;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && gen;

    always_comb begin
        n_state    = r_state;
        n_pending  = r_pending;
        n_held_cmd = r_held_cmd;
        gen        = 1'b0;
        o_token    = '{op: tisp_pkg::OP_DATA, a: i_byte, b: 8'd0};
        if (accept) begin
            unique case (r_state)
                ST_DATA: begin
                    if (i_byte == tisp_pkg::B_IAC) begin
                        n_state = ST_CMD;
                    end else begin
                        gen = 1'b1;
                    end
                end
                ST_CMD: begin
                    if (i_byte == tisp_pkg::B_IAC) begin
                        n_state = ST_DATA;
                        gen     = 1'b1;
                    end else if (i_byte == tisp_pkg::B_SB || i_byte >= tisp_pkg::B_WILL) begin
                        n_held_cmd = i_byte;
                        n_state    = ST_OPT;
                    end else begin
                        n_state    = ST_DATA;
                        gen        = 1'b1;
                        o_token.op = tisp_pkg::OP_CTRL;
                    end
                end
                ST_OPT: begin
                    gen = 1'b1;
                    if (r_held_cmd == tisp_pkg::B_SB) begin
                        n_state    = ST_SUB;
                        n_pending  = 1'b0;
                        o_token.op = tisp_pkg::OP_SUB_START;
                    end else begin
                        n_state    = ST_DATA;
                        o_token.op = tisp_pkg::OP_NEG;
                        o_token.a  = r_held_cmd;
                        o_token.b  = i_byte;
                    end
                end
                ST_SUB: begin
                    if (r_pending) begin
                        n_pending = 1'b0;
                        gen       = 1'b1;
                        if (i_byte == tisp_pkg::B_SE) begin
                            n_state    = ST_DATA;
                            o_token.op = tisp_pkg::OP_SUB_END;
                        end else begin
                            o_token.op = tisp_pkg::OP_SUB_BYTE;
                        end
                    end else if (i_byte == tisp_pkg::B_IAC) begin
                        n_pending = 1'b1;
                    end else begin
                        gen        = 1'b1;
                        o_token.op = tisp_pkg::OP_SUB_BYTE;
                    end
                end
                default: begin
                    n_state = ST_DATA;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_DATA;
            r_pending  <= 1'b0;
            r_held_cmd <= 8'd0;
        end else begin
            r_state    <= n_state;
            r_pending  <= n_pending;
            r_held_cmd <= n_held_cmd;
        end
    end

endmodule
`default_nettype wire

>>> rtl/tisp_queue.sv
`default_nettype none
`include "telnet_iac_stream_parser_top_assert.svh"
module tisp_queue (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_push,
    input  tisp_pkg::t_token          i_token,
    input  wire                       i_pop,
    output tisp_pkg::t_token          o_token,
    output tisp_pkg::t_queue_status   o_status
);

    tisp_pkg::t_token                     r_mem [tisp_pkg::QUEUE_DEPTH];
    logic [tisp_pkg::QUEUE_PTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [tisp_pkg::QUEUE_CNT_W-1:0]     r_count;
    logic                                 do_push, do_pop;

    assign o_status.full  = (r_count == tisp_pkg::QUEUE_CNT_W'(tisp_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_token        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + tisp_pkg::QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + tisp_pkg::QUEUE_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + tisp_pkg::QUEUE_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - tisp_pkg::QUEUE_CNT_W'(1);
            end
        end
    end

    `TISP_ASSERT_NEVER(a_count_range, (r_count > tisp_pkg::QUEUE_CNT_W'(tisp_pkg::QUEUE_DEPTH)), "Queue occupancy exceeds its depth.")
    `TISP_ASSERT(a_empty_ptrs, (o_status.empty |-> (r_wr_ptr == r_rd_ptr)), "Empty queue has unequal pointers.")
    `TISP_ASSERT(a_push_grows, ((do_push && !do_pop) |=> (r_count == $past(r_count) + tisp_pkg::QUEUE_CNT_W'(1))), "Queue occupancy did not grow on a push.")

endmodule
`default_nettype wire

>>> rtl/tisp_back.sv
`default_nettype none
module tisp_back (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  tisp_pkg::t_token          i_token,
    input  tisp_pkg::t_queue_status   i_status,
    output logic                      o_pop,
    input  wire                       i_tready,
    output logic                      o_tvalid,
    output logic [39:0]               o_tdata,
    output logic [2:0]                o_tuser
);

    localparam int LEN_W = (tisp_pkg::SUB_COUNT_BITS > 16) ? tisp_pkg::SUB_COUNT_BITS : 16;

    logic                                   r_valid;
    tisp_pkg::t_kind                        r_kind, n_kind;
    logic [7:0]                             r_value, n_value;
    logic [7:0]                             r_cmd, n_cmd;
    logic [7:0]                             r_opt, n_opt;
    logic [15:0]                            r_len, n_len;
    logic [7:0]                             r_sub_opt, n_sub_opt;
    logic [tisp_pkg::SUB_COUNT_BITS-1:0]    r_count, n_count;
    logic [LEN_W-1:0]                       count_ext;
    logic [15:0]                            sat_len;
    logic                                   emit;

    assign o_pop    = !i_status.empty && (!r_valid || i_tready);
    assign o_tvalid = r_valid;
    assign o_tdata  = {r_len, r_opt, r_cmd, r_value};
    assign o_tuser  = r_kind;
    assign count_ext = LEN_W'(r_count);
    assign sat_len  = (count_ext > LEN_W'(16'hFFFF)) ? 16'hFFFF : count_ext[15:0];

    always_comb begin
        n_kind    = tisp_pkg::KIND_DATA;
        n_value   = 8'd0;
        n_cmd     = 8'd0;
        n_opt     = 8'd0;
        n_len     = 16'd0;
        n_sub_opt = r_sub_opt;
        n_count   = r_count;
        emit      = 1'b0;
        if (o_pop) begin
            unique case (i_token.op)
                tisp_pkg::OP_DATA: begin
                    emit    = 1'b1;
                    n_value = i_token.a;
                end
                tisp_pkg::OP_CTRL: begin
                    emit   = 1'b1;
                    n_kind = tisp_pkg::KIND_CTRL;
                    n_cmd  = i_token.a;
                end
                tisp_pkg::OP_NEG: begin
                    emit   = 1'b1;
                    n_kind = tisp_pkg::KIND_NEG;
                    n_cmd  = i_token.a;
                    n_opt  = i_token.b;
                end
                tisp_pkg::OP_SUB_START: begin
                    n_sub_opt = i_token.a;
                    n_count   = '0;
                end
                tisp_pkg::OP_SUB_BYTE: begin
                    emit    = 1'b1;
                    n_kind  = tisp_pkg::KIND_SUBB;
                    n_value = i_token.a;
                    n_opt   = r_sub_opt;
                    if (r_count != '1) begin
                        n_count = r_count + tisp_pkg::SUB_COUNT_BITS'(1);
                    end
                end
                tisp_pkg::OP_SUB_END: begin
                    emit    = 1'b1;
                    n_kind  = tisp_pkg::KIND_SUBE;
                    n_opt   = r_sub_opt;
                    n_len   = sat_len;
                    n_count = '0;
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_sub_opt <= 8'd0;
            r_count   <= '0;
        end else begin
            r_sub_opt <= n_sub_opt;
            r_count   <= n_count;
            if (emit) begin
                r_valid <= 1'b1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind  <= n_kind;
            r_value <= n_value;
            r_cmd   <= n_cmd;
            r_opt   <= n_opt;
            r_len   <= n_len;
        end
    end

endmodule
`default_nettype wire

>>> rtl/telnet_iac_stream_parser_top.sv
// Telnet receive-side IAC parser. One received byte is taken per transfer on the slave
// side, and a new byte can be accepted every clock cycle while the queue is not full. Each
// byte gives zero or one result on the master side; a result passes through the parsing
// stage, a four-entry queue and the output register. The queue lets the parser keep accepting
// bytes while the master side stalls, until the queue is full.
`default_nettype none
module telnet_iac_stream_parser_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [7:0]   i_s_tdata,    // [7:0] rx_byte
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [39:0]  o_m_tdata,    // [7:0] out_value, [15:8] command_code,
                                       // [23:16] option_code, [39:24] sub_length
    output logic [2:0]   o_m_tuser     // [2:0] kind
);

    logic                       push;
    logic                       pop;
    tisp_pkg::t_token           push_token;
    tisp_pkg::t_token           pop_token;
    tisp_pkg::t_queue_status    status;

    tisp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_byte  (i_s_tdata),
        .i_full  (status.full),
        .o_ready (o_s_tready),
        .o_push  (push),
        .o_token (push_token)
    );

    tisp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_token  (push_token),
        .i_pop    (pop),
        .o_token  (pop_token),
        .o_status (status)
    );

    tisp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_token  (pop_token),
        .i_status (status),
        .o_pop    (pop),
        .i_tready (i_m_tready),
        .o_tvalid (o_m_tvalid),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser)
    );

endmodule
`default_nettype wire
